// ===== hdl/hsu_pkg.sv =====
// Shared types and constants for the stepper homing sequencer.
package hsu_pkg;

    localparam int unsigned LIMIT_W = 20;
    localparam int unsigned COUNT_W = 16;
    localparam int unsigned CFG_ADDR_W = 2;
    localparam int unsigned CFG_DATA_W = 20;
    localparam int unsigned S_TDATA_W = 8;
    localparam int unsigned M_TDATA_W = 24;

    localparam logic [CFG_ADDR_W-1:0] CFG_SEARCH_LIMIT = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_CENTER_STEPS = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_OVERTRAVEL_STEPS = 2'd2;

    localparam logic [LIMIT_W-1:0] SEARCH_LIMIT_RST = 20'd65535;
    localparam logic [COUNT_W-1:0] CENTER_STEPS_RST = 16'd1000;
    localparam logic [COUNT_W-1:0] OVERTRAVEL_STEPS_RST = 16'd10;

    localparam logic OP_START = 1'b0;
    localparam logic OP_TICK = 1'b1;

    typedef struct packed {
        logic operation;
        logic limit_switch;
        logic abort_request;
    } hsu_item_t;

    typedef struct packed {
        logic               step_pulse;
        logic               toward_switch;
        logic               busy_res;
        logic               fault;
        logic               homed;
        logic [COUNT_W-1:0] axis_position;
    } hsu_result_t;

    typedef struct packed {
        logic                  wr_en;
        logic [CFG_ADDR_W-1:0] addr;
        logic [CFG_DATA_W-1:0] wdata;
    } hsu_cfg_wr_t;

endpackage

// ===== hdl/hsu_core.sv =====
// Homing state, configuration registers and the per-word next-state logic.
module hsu_core import hsu_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  hsu_cfg_wr_t cfg_wr,
    input  logic        item_fire,
    input  hsu_item_t   item,
    output hsu_result_t result
);

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_BACKOFF,
        PH_SEEK,
        PH_OVER,
        PH_CENTER
    } phase_t;

    logic [LIMIT_W-1:0] search_limit_reg;
    logic [COUNT_W-1:0] center_steps_reg;
    logic [COUNT_W-1:0] overtravel_steps_reg;

    phase_t             phase_reg, phase_next;
    logic [LIMIT_W-1:0] step_count_reg, step_count_next;
    logic [COUNT_W-1:0] position_reg, position_next;
    logic               fault_reg, fault_next;
    logic               done_reg, done_next;
    logic               dir_reg, dir_next;

    logic               pulse;
    logic               dir_used;
    logic [LIMIT_W-1:0] step_inc;
    logic [COUNT_W-1:0] pos_inc;
    logic [LIMIT_W-1:0] center_ext;
    logic [LIMIT_W-1:0] over_ext;
    logic               center_zero;

    assign step_inc    = step_count_reg + LIMIT_W'(1);
    assign pos_inc     = position_reg + COUNT_W'(1);
    assign center_ext  = LIMIT_W'(center_steps_reg);
    assign over_ext    = LIMIT_W'(overtravel_steps_reg);
    assign center_zero = (center_steps_reg == '0);

    always_comb begin
        phase_next      = phase_reg;
        step_count_next = step_count_reg;
        position_next   = position_reg;
        fault_next      = fault_reg;
        done_next       = done_reg;
        dir_next        = dir_reg;
        pulse           = 1'b0;
        dir_used        = 1'b0;

        if (item.operation == OP_START) begin
            fault_next      = 1'b0;
            done_next       = 1'b0;
            step_count_next = '0;
            if (item.limit_switch && !center_zero) begin
                phase_next = PH_BACKOFF;
                dir_next   = 1'b0;
            end else begin
                phase_next = PH_SEEK;
                dir_next   = 1'b1;
            end
        end else if (phase_reg != PH_IDLE) begin
            if (item.abort_request) begin
                if (phase_reg == PH_SEEK) begin
                    fault_next = 1'b1;
                end
                phase_next = PH_IDLE;
            end else begin
                unique case (phase_reg)
                    PH_BACKOFF: begin
                        pulse = 1'b1;
                        if (step_inc >= center_ext) begin
                            phase_next      = PH_SEEK;
                            dir_next        = 1'b1;
                            step_count_next = '0;
                        end else begin
                            step_count_next = step_inc;
                        end
                    end
                    PH_SEEK: begin
                        if (item.limit_switch) begin
                            step_count_next = '0;
                            if (overtravel_steps_reg == '0) begin
                                // Straight into centering; any first step goes out now.
                                dir_next = 1'b0;
                                if (center_zero) begin
                                    position_next = '0;
                                    phase_next    = PH_IDLE;
                                    done_next     = 1'b1;
                                end else begin
                                    pulse         = 1'b1;
                                    position_next = COUNT_W'(1);
                                    if (center_steps_reg == COUNT_W'(1)) begin
                                        phase_next = PH_IDLE;
                                        done_next  = 1'b1;
                                    end else begin
                                        phase_next = PH_CENTER;
                                    end
                                end
                            end else begin
                                // First overtravel step goes out on the same tick.
                                pulse           = 1'b1;
                                dir_used        = 1'b1;
                                step_count_next = LIMIT_W'(1);
                                if (overtravel_steps_reg == COUNT_W'(1)) begin
                                    position_next = '0;
                                    dir_next      = 1'b0;
                                    if (center_zero) begin
                                        phase_next = PH_IDLE;
                                        done_next  = 1'b1;
                                    end else begin
                                        phase_next = PH_CENTER;
                                    end
                                end else begin
                                    phase_next = PH_OVER;
                                end
                            end
                        end else begin
                            pulse    = 1'b1;
                            dir_used = 1'b1;
                            if (step_count_reg >= search_limit_reg) begin
                                fault_next = 1'b1;
                                phase_next = PH_IDLE;
                            end else begin
                                step_count_next = step_inc;
                            end
                        end
                    end
                    PH_OVER: begin
                        pulse           = 1'b1;
                        dir_used        = 1'b1;
                        step_count_next = step_inc;
                        if (step_inc >= over_ext) begin
                            position_next = '0;
                            dir_next      = 1'b0;
                            if (center_zero) begin
                                phase_next = PH_IDLE;
                                done_next  = 1'b1;
                            end else begin
                                phase_next = PH_CENTER;
                            end
                        end
                    end
                    PH_CENTER: begin
                        pulse         = 1'b1;
                        position_next = pos_inc;
                        if (pos_inc >= center_steps_reg) begin
                            phase_next = PH_IDLE;
                            done_next  = 1'b1;
                        end
                    end
                    default: begin
                        phase_next = PH_IDLE;
                    end
                endcase
            end
        end
    end

    always_comb begin
        result.step_pulse    = pulse;
        result.toward_switch = pulse ? dir_used : dir_next;
        result.busy_res      = (phase_next != PH_IDLE);
        result.fault         = fault_next;
        result.homed         = done_next;
        result.axis_position = position_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            search_limit_reg     <= SEARCH_LIMIT_RST;
            center_steps_reg     <= CENTER_STEPS_RST;
            overtravel_steps_reg <= OVERTRAVEL_STEPS_RST;
        end else if (cfg_wr.wr_en) begin
            unique case (cfg_wr.addr)
                CFG_SEARCH_LIMIT:     search_limit_reg     <= cfg_wr.wdata[LIMIT_W-1:0];
                CFG_CENTER_STEPS:     center_steps_reg     <= cfg_wr.wdata[COUNT_W-1:0];
                CFG_OVERTRAVEL_STEPS: overtravel_steps_reg <= cfg_wr.wdata[COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_IDLE;
            step_count_reg <= '0;
            position_reg   <= '0;
            fault_reg      <= 1'b0;
            done_reg       <= 1'b0;
            dir_reg        <= 1'b1;
        end else if (item_fire) begin
            phase_reg      <= phase_next;
            step_count_reg <= step_count_next;
            position_reg   <= position_next;
            fault_reg      <= fault_next;
            done_reg       <= done_next;
            dir_reg        <= dir_next;
        end
    end

endmodule

// ===== hdl/stepper_homing_sequencer_unit.sv =====
// Homing sequencer for one stepper axis: an input word register, the homing core and
// a result word register. Each input word is processed combinationally between the
// input register and the result register, so the block takes one word per clock while
// the result register is empty or being drained; an accepted word passes through the
// input register and then the result register before it is presented. The input side
// accepts a word while its register is empty or while its stored word moves on.
// Only the homing phase, the step and position counts, fault, done and direction are carried from word to word.
// Configuration writes go straight to the registers and take effect on the next word.
module stepper_homing_sequencer_unit import hsu_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,  // [0] limit_switch, [1] abort_request, rest zero
    input  logic                  s_tuser,  // [0] operation
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata   // [0] step_pulse, [1] toward_switch,
                                            // [2] busy_res, [3] fault, [4] homed,
                                            // [20:5] axis_position, rest zero
);

    logic        in_valid_reg;
    hsu_item_t   in_item_reg;
    logic        out_valid_reg;
    hsu_result_t out_result_reg;

    logic        fire;
    hsu_result_t result;
    hsu_cfg_wr_t cfg_wr;

    // A stored word moves on whenever the result register is empty or being drained.
    assign fire     = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || fire;

    assign cfg_wr.wr_en = cfg_wr_en;
    assign cfg_wr.addr  = cfg_addr;
    assign cfg_wr.wdata = cfg_wdata;

    hsu_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr    (cfg_wr),
        .item_fire (fire),
        .item      (in_item_reg),
        .result    (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_item_reg.operation     <= s_tuser;
            in_item_reg.limit_switch  <= s_tdata[0];
            in_item_reg.abort_request <= s_tdata[1];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (fire) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            out_result_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000,
                       out_result_reg.axis_position,
                       out_result_reg.homed,
                       out_result_reg.fault,
                       out_result_reg.busy_res,
                       out_result_reg.toward_switch,
                       out_result_reg.step_pulse};

    // A fault and a normal finish are never reported together.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(out_result_reg.fault && out_result_reg.homed))
        else $error("fault and homed set together");

    // A step that ends the sequence either trips the search limit or completes homing.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && out_result_reg.step_pulse && !out_result_reg.busy_res)
            |-> (out_result_reg.fault || out_result_reg.homed))
        else $error("sequence stopped on a step without fault or done");

    // A word held in the input register is not dropped before it is processed.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !fire) |=> (in_valid_reg && $stable(in_item_reg)))
        else $error("input word lost while waiting");

    // A result is loaded only into an empty or draining result register.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(out_result_reg)))
        else $error("result word overwritten while stalled");

endmodule
